[hw/rtl/gcc_pkg.sv]
package gcc_pkg;

    // sizing
    localparam int VERTEX_COUNT = 32768;
    localparam int MAX_COLORS   = 64;
    localparam int MAX_ITEMS    = 262144;

    // fixed field widths
    localparam int VERTEX_W    = 15;
    localparam int COLOR_W     = 6;
    localparam int RANK_W      = 18;
    localparam int USED_W      = 7;
    localparam int COLOR_SLOTS = 64;
    localparam int RANK_MAX    = 262143;

    // derived
    localparam int VIDX_W      = $clog2(VERTEX_COUNT);
    localparam int CIDX_W      = $clog2(MAX_COLORS);
    localparam int COUNT_LIMIT = (MAX_ITEMS - 1 < RANK_MAX) ? MAX_ITEMS - 1 : RANK_MAX;
    localparam int CLR_N       = (VERTEX_COUNT > MAX_COLORS) ? VERTEX_COUNT : MAX_COLORS;
    localparam int CLR_W       = $clog2(CLR_N);

    // colors at or above MAX_COLORS always read as taken
    localparam logic [COLOR_SLOTS-1:0] ALLOWED_MASK =
        (COLOR_SLOTS'(1) << MAX_COLORS) - COLOR_SLOTS'(1);

    // APB register map
    localparam int PADDR_W = 3;
    localparam int DATA_W  = 32;
    localparam logic [PADDR_W-3:0] REG_FOUR_VERTEX_MODE = '0;

    typedef struct packed {
        logic                  rd_en;
        logic [VIDX_W-1:0]     rd_addr_a;
        logic [VIDX_W-1:0]     rd_addr_b;
        logic                  wr_en;
        logic [VIDX_W-1:0]     wr_addr;
        logic [MAX_COLORS-1:0] wr_data;
    } mask_req_t;

    typedef struct packed {
        logic              rd_en;
        logic [CIDX_W-1:0] rd_addr;
        logic              wr_en;
        logic [CIDX_W-1:0] wr_addr;
        logic [RANK_W-1:0] wr_data;
    } cnt_req_t;

    function automatic logic in_range(input logic [VERTEX_W-1:0] v);
        return {2'b00, v} < (VERTEX_W + 2)'(VERTEX_COUNT);
    endfunction

    // lowest zero bit: first within each byte, then first byte with a zero
    function automatic logic [COLOR_W-1:0] first_free(input logic [COLOR_SLOTS-1:0] busy);
        logic [7:0] grp_free;
        logic [2:0] pos [8];
        logic [2:0] g_sel;
        logic       done;
        begin
            g_sel = '0;
            for (int g = 0; g < 8; g++)
            begin
                grp_free[g] = ~&busy[g*8 +: 8];
                pos[g]      = '0;
                done        = 1'b0;
                for (int k = 0; k < 8; k++)
                begin
                    if (!done && !busy[g*8 + k])
                    begin
                        pos[g] = 3'(k);
                        done   = 1'b1;
                    end
                end
            end
            done = 1'b0;
            for (int g = 0; g < 8; g++)
            begin
                if (!done && grp_free[g])
                begin
                    g_sel = 3'(g);
                    done  = 1'b1;
                end
            end
            return {g_sel, pos[g_sel]};
        end
    endfunction

endpackage

[hw/rtl/gcc_if.sv]
interface gcc_item_if import gcc_pkg::*;;
    logic                valid;
    logic                ready;
    logic [VERTEX_W-1:0] vertex_0;
    logic [VERTEX_W-1:0] vertex_1;
    logic [VERTEX_W-1:0] vertex_2;
    logic [VERTEX_W-1:0] vertex_3;

    modport source (output valid, vertex_0, vertex_1, vertex_2, vertex_3, input ready);
    modport sink   (input valid, vertex_0, vertex_1, vertex_2, vertex_3, output ready);
endinterface

interface gcc_result_if import gcc_pkg::*;;
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] color;
    logic [RANK_W-1:0]  rank_in_color;
    logic [USED_W-1:0]  colors_used;
    logic               overflow;

    modport source (output valid, color, rank_in_color, colors_used, overflow, input ready);
    modport sink   (input valid, color, rank_in_color, colors_used, overflow, output ready);
endinterface

[hw/rtl/greedy_conflict_coloring.sv]
// Channel  | Dir | Handshake     | Payload
// item     | in  | valid/ready   | vertex_0..vertex_3 (15b each)
// result   | out | valid/ready   | color, rank_in_color, colors_used, overflow
// apb      | in  | psel/penable  | reg 0 @ 0x0: four_vertex_mode (bit 0)
//
// Sequence: mask reads (a second pair for four vertices), color pick, one mask write
// per vertex, then the result register load; one idle state before the next accept.
// With no free color the writes are skipped.
// A dropped request (equal pair, vertex out of range) leaves the block in idle.
// The pace is set by the single write port of the mask store (one mask write per
// vertex) and the registered reads of the mask and count memories.
// Reset: a clearing pass zeroes the mask store and the per-color counts, one entry a
// cycle, max(VERTEX_COUNT, MAX_COLORS) = 32768 entries; item.ready stays low meanwhile.
// Stalls: a finished result waits in the output register; a new request is taken
// while it waits, and only the next result load waits on result.ready.
module greedy_conflict_coloring import gcc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    gcc_item_if.sink           item,
    gcc_result_if.source       result
);

    logic                  mode_reg, mode_next;
    logic                  wr_fire;
    logic [PADDR_W-3:0]    reg_idx;

    mask_req_t             mask_req;
    logic [MAX_COLORS-1:0] mask_rd_a;
    logic [MAX_COLORS-1:0] mask_rd_b;
    cnt_req_t              cnt_req;
    logic [RANK_W-1:0]     cnt_rd;

    // APB slave: zero wait states, word-addressed registers
    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_fire = psel && penable && pwrite && pready;

    always_comb
    begin
        mode_next = mode_reg;
        if (wr_fire && (reg_idx == REG_FOUR_VERTEX_MODE))
        begin
            mode_next = pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_FOUR_VERTEX_MODE)
        begin
            prdata = DATA_W'(mode_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    // sequencer owns the read-modify-write order; masks and counts never
    // see a read and a write to the same entry in one request window
    gcc_seq u_seq (
        .clk              (clk),
        .rst_n            (rst_n),
        .four_vertex_mode (mode_reg),
        .item             (item),
        .result           (result),
        .mask_req         (mask_req),
        .mask_rd_a        (mask_rd_a),
        .mask_rd_b        (mask_rd_b),
        .cnt_req          (cnt_req),
        .cnt_rd           (cnt_rd)
    );

    gcc_mask_store u_mask_store (
        .clk  (clk),
        .req  (mask_req),
        .rd_a (mask_rd_a),
        .rd_b (mask_rd_b)
    );

    gcc_count_store u_count_store (
        .clk     (clk),
        .req     (cnt_req),
        .rd_data (cnt_rd)
    );

endmodule

[hw/rtl/gcc_mask_store.sv]
// per-vertex used-color masks, two registered read ports, one write port
module gcc_mask_store import gcc_pkg::*;
(
    input  logic                  clk,
    input  mask_req_t             req,
    output logic [MAX_COLORS-1:0] rd_a,
    output logic [MAX_COLORS-1:0] rd_b
);

    logic [MAX_COLORS-1:0] mem [VERTEX_COUNT];
    logic [MAX_COLORS-1:0] rd_a_reg;
    logic [MAX_COLORS-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_a_reg <= mem[req.rd_addr_a];
            rd_b_reg <= mem[req.rd_addr_b];
        end
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

[hw/rtl/gcc_count_store.sv]
// per-color request counts, registered read
module gcc_count_store import gcc_pkg::*;
(
    input  logic              clk,
    input  cnt_req_t          req,
    output logic [RANK_W-1:0] rd_data
);

    logic [RANK_W-1:0] mem [MAX_COLORS];
    logic [RANK_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/gcc_seq.sv]
// request sequencer: clear pass, mask reads, color pick, write-back, result register
module gcc_seq import gcc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  four_vertex_mode,
    gcc_item_if.sink              item,
    gcc_result_if.source          result,
    output mask_req_t             mask_req,
    input  logic [MAX_COLORS-1:0] mask_rd_a,
    input  logic [MAX_COLORS-1:0] mask_rd_b,
    output cnt_req_t              cnt_req,
    input  logic [RANK_W-1:0]     cnt_rd
);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_READ1  = 7'b0000100,
        S_READ2  = 7'b0001000,
        S_PICK   = 7'b0010000,
        S_WRITE  = 7'b0100000,
        S_FINISH = 7'b1000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CLR_W-1:0]       clr_reg, clr_next;
    logic [USED_W-1:0]      total_reg, total_next;
    logic                   out_valid_reg, out_valid_next;

    logic                   mode_reg, mode_next;
    logic [VIDX_W-1:0]      v_reg [4];
    logic [VIDX_W-1:0]      v_next [4];
    logic [MAX_COLORS-1:0]  m_reg [4];
    logic [MAX_COLORS-1:0]  m_next [4];
    logic [COLOR_SLOTS-1:0] busy_reg, busy_next;
    logic [COLOR_W-1:0]     color_reg, color_next;
    logic [1:0]             widx_reg, widx_next;
    logic [COLOR_W-1:0]     res_color_reg, res_color_next;
    logic [RANK_W-1:0]      res_rank_reg, res_rank_next;
    logic [USED_W-1:0]      res_used_reg, res_used_next;
    logic                   res_ovf_reg, res_ovf_next;
    logic [COLOR_W-1:0]     out_color_reg, out_color_next;
    logic [RANK_W-1:0]      out_rank_reg, out_rank_next;
    logic [USED_W-1:0]      out_used_reg, out_used_next;
    logic                   out_ovf_reg, out_ovf_next;

    logic                   item_fire;
    logic                   in_drop;
    logic [COLOR_W-1:0]     pick;
    logic [MAX_COLORS-1:0]  color_bit;
    logic [USED_W-1:0]      color_plus;
    logic [USED_W-1:0]      used_new;
    logic                   last_write;

    assign item.ready = (state_reg == S_IDLE);
    assign item_fire  = item.valid && item.ready;

    // degenerate pair or vertex out of range: no result, no state change
    assign in_drop = (!four_vertex_mode && (item.vertex_0 == item.vertex_1))
                  || !in_range(item.vertex_0) || !in_range(item.vertex_1)
                  || (four_vertex_mode
                      && (!in_range(item.vertex_2) || !in_range(item.vertex_3)));

    assign pick       = first_free(busy_reg);
    assign color_bit  = MAX_COLORS'(1) << color_reg;
    assign color_plus = USED_W'(color_reg) + USED_W'(1);
    assign used_new   = (color_plus > total_reg) ? color_plus : total_reg;
    assign last_write = mode_reg ? (widx_reg == 2'd3) : (widx_reg == 2'd1);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg;
        mode_next      = mode_reg;
        v_next         = v_reg;
        m_next         = m_reg;
        busy_next      = busy_reg;
        color_next     = color_reg;
        widx_next      = widx_reg;
        res_color_next = res_color_reg;
        res_rank_next  = res_rank_reg;
        res_used_next  = res_used_reg;
        res_ovf_next   = res_ovf_reg;
        out_color_next = out_color_reg;
        out_rank_next  = out_rank_reg;
        out_used_next  = out_used_reg;
        out_ovf_next   = out_ovf_reg;
        mask_req       = '0;
        cnt_req        = '0;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mask_req.wr_en   = ({1'b0, clr_reg} < (CLR_W + 1)'(VERTEX_COUNT));
                mask_req.wr_addr = VIDX_W'(clr_reg);
                mask_req.wr_data = '0;
                cnt_req.wr_en    = ({1'b0, clr_reg} < (CLR_W + 1)'(MAX_COLORS));
                cnt_req.wr_addr  = CIDX_W'(clr_reg);
                cnt_req.wr_data  = '0;
                if (clr_reg == CLR_W'(CLR_N - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + CLR_W'(1);
                end
            end
            S_IDLE:
            begin
                if (item_fire && !in_drop)
                begin
                    v_next[0]          = VIDX_W'(item.vertex_0);
                    v_next[1]          = VIDX_W'(item.vertex_1);
                    v_next[2]          = VIDX_W'(item.vertex_2);
                    v_next[3]          = VIDX_W'(item.vertex_3);
                    mode_next          = four_vertex_mode;
                    busy_next          = ~ALLOWED_MASK;
                    mask_req.rd_en     = 1'b1;
                    mask_req.rd_addr_a = VIDX_W'(item.vertex_0);
                    mask_req.rd_addr_b = VIDX_W'(item.vertex_1);
                    state_next         = S_READ1;
                end
            end
            S_READ1:
            begin
                busy_next = busy_reg | COLOR_SLOTS'(mask_rd_a) | COLOR_SLOTS'(mask_rd_b);
                m_next[0] = mask_rd_a;
                m_next[1] = mask_rd_b;
                if (mode_reg)
                begin
                    mask_req.rd_en     = 1'b1;
                    mask_req.rd_addr_a = v_reg[2];
                    mask_req.rd_addr_b = v_reg[3];
                    state_next         = S_READ2;
                end
                else
                begin
                    state_next = S_PICK;
                end
            end
            S_READ2:
            begin
                busy_next  = busy_reg | COLOR_SLOTS'(mask_rd_a) | COLOR_SLOTS'(mask_rd_b);
                m_next[2]  = mask_rd_a;
                m_next[3]  = mask_rd_b;
                state_next = S_PICK;
            end
            S_PICK:
            begin
                if (&busy_reg)
                begin
                    // no free color: report only, state untouched
                    res_color_next = '0;
                    res_rank_next  = '0;
                    res_used_next  = total_reg;
                    res_ovf_next   = 1'b1;
                    state_next     = S_FINISH;
                end
                else
                begin
                    color_next      = pick;
                    cnt_req.rd_en   = 1'b1;
                    cnt_req.rd_addr = CIDX_W'(pick);
                    widx_next       = '0;
                    state_next      = S_WRITE;
                end
            end
            S_WRITE:
            begin
                mask_req.wr_en   = 1'b1;
                mask_req.wr_addr = v_reg[widx_reg];
                mask_req.wr_data = m_reg[widx_reg] | color_bit;
                if (widx_reg == 2'd0)
                begin
                    res_color_next  = color_reg;
                    res_rank_next   = cnt_rd;
                    res_used_next   = used_new;
                    res_ovf_next    = 1'b0;
                    total_next      = used_new;
                    cnt_req.wr_en   = (cnt_rd < RANK_W'(COUNT_LIMIT));
                    cnt_req.wr_addr = CIDX_W'(color_reg);
                    cnt_req.wr_data = cnt_rd + RANK_W'(1);
                end
                if (last_write)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    widx_next = widx_reg + 2'd1;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_color_next = res_color_reg;
                    out_rank_next  = res_rank_reg;
                    out_used_next  = res_used_reg;
                    out_ovf_next   = res_ovf_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        v_reg         <= v_next;
        m_reg         <= m_next;
        busy_reg      <= busy_next;
        color_reg     <= color_next;
        widx_reg      <= widx_next;
        res_color_reg <= res_color_next;
        res_rank_reg  <= res_rank_next;
        res_used_reg  <= res_used_next;
        res_ovf_reg   <= res_ovf_next;
        out_color_reg <= out_color_next;
        out_rank_reg  <= out_rank_next;
        out_used_reg  <= out_used_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.color         = out_color_reg;
    assign result.rank_in_color = out_rank_reg;
    assign result.colors_used   = out_used_reg;
    assign result.overflow      = out_ovf_reg;

endmodule

[hw/rtl/gcc_checker.sv]
module gcc_checker import gcc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               result_valid,
    input logic               result_ready,
    input logic [COLOR_W-1:0] color,
    input logic [RANK_W-1:0]  rank_in_color,
    input logic [USED_W-1:0]  colors_used,
    input logic               overflow
);

    // overflow means every color is in use somewhere
    a_ovf_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && overflow |->
            color == '0 && rank_in_color == '0 && colors_used == USED_W'(MAX_COLORS))
        else $error("overflow result with bad fields");

    a_color_counted: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !overflow |-> USED_W'(color) < colors_used)
        else $error("assigned color not covered by colors_used");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> colors_used <= USED_W'(MAX_COLORS))
        else $error("colors_used beyond color limit");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(color) && $stable(rank_in_color)
            && $stable(colors_used) && $stable(overflow))
        else $error("stalled result changed");

endmodule

bind greedy_conflict_coloring gcc_checker u_gcc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .color         (result.color),
    .rank_in_color (result.rank_in_color),
    .colors_used   (result.colors_used),
    .overflow      (result.overflow)
);

[tb/greedy_conflict_coloring_test.sv]
`timescale 1ns / 1ps

module greedy_conflict_coloring_test;
    import gcc_pkg::*;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 8;
    // longest legal quiet stretch is the clearing pass after reset
    localparam int IDLE_LIMIT      = 131072;
    // settle time covers a four-vertex request and a dropped one, with margin on top
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_PHASES   = 4;
    localparam int PHASE_QUOTA     = 360;
    localparam int MAX_REPORTS     = 40;

    localparam int REG_MODE_INDEX  = int'(REG_FOUR_VERTEX_MODE);
    // first index past the register map; writes there must be ignored
    localparam int REG_SPARE_INDEX = REG_MODE_INDEX + 1;

    typedef logic [VERTEX_W-1:0] vertex_t;

    typedef struct packed {
        vertex_t vertex_0;
        vertex_t vertex_1;
        vertex_t vertex_2;
        vertex_t vertex_3;
    } vertex_set_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [RANK_W-1:0]  rank_in_color;
        logic [USED_W-1:0]  colors_used;
        logic               overflow;
    } coloring_t;

    // ROW_ITEM: checked against the predictor
    // ROW_TYPED: result typed into the table
    // ROW_DROPPED: request must give no result
    // ROW_CFG: register write between phases
    typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_DROPPED, ROW_CFG} row_kind_e;

    typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_HEAVY} stall_style_e;

    typedef struct packed {
        row_kind_e         kind;
        logic [7:0]        reg_index;
        logic [DATA_W-1:0] reg_value;
        vertex_set_t       req;
        coloring_t         result;
    } stim_row_t;

    localparam int DIRECTED_COUNT = 21;

    // Directed part. Starts in pair mode right after reset, so the first
    // few results are obvious: fresh vertices take color 0, a repeated pair
    // climbs to the next color, ranks count per color.
    localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{ROW_TYPED,   '0, '0, '{15'd1, 15'd2, 15'd0, 15'd0},
          '{6'd0, 18'd0, 7'd1, 1'b0}},
        // same pair again; vertex_2/3 at max are ignored in pair mode
        '{ROW_TYPED,   '0, '0, '{15'd1, 15'd2, 15'h7FFF, 15'h7FFF},
          '{6'd1, 18'd0, 7'd2, 1'b0}},
        // equal pair is dropped
        '{ROW_DROPPED, '0, '0, '{15'd5, 15'd5, 15'd0, 15'd0}, '0},
        // index extremes
        '{ROW_TYPED,   '0, '0, '{15'd0, 15'h7FFF, 15'h7FFF, 15'h7FFF},
          '{6'd0, 18'd1, 7'd2, 1'b0}},
        '{ROW_ITEM,    '0, '0, '{15'h7FFF, 15'd0, 15'h5555, 15'h2AAA}, '0},
        '{ROW_ITEM,    '0, '0, '{15'h7FFF, 15'd0, 15'h2AAA, 15'h5555}, '0},
        '{ROW_DROPPED, '0, '0, '{15'h7FFF, 15'h7FFF, 15'd0, 15'd0}, '0},
        '{ROW_DROPPED, '0, '0, '{15'd0, 15'd0, 15'h7FFF, 15'h7FFF}, '0},
        '{ROW_ITEM,    '0, '0, '{15'd1, 15'd0, 15'd0, 15'd0}, '0},
        // write past the register map: mode must stay pair mode
        '{ROW_CFG, 8'(REG_SPARE_INDEX), 32'hFFFF_FFFF, '0, '0},
        '{ROW_ITEM,    '0, '0, '{15'd2, 15'd6, 15'd0, 15'd0}, '0},
        '{ROW_CFG, 8'(REG_MODE_INDEX), 32'hFFFF_FFFF, '0, '0},
        // tetrahedra, repeated vertices included
        '{ROW_ITEM,    '0, '0, '{15'd7, 15'd7, 15'd7, 15'd7}, '0},
        '{ROW_ITEM,    '0, '0, '{15'd0, 15'd1, 15'd2, 15'h7FFF}, '0},
        '{ROW_ITEM,    '0, '0, '{15'd10, 15'd11, 15'd12, 15'd13}, '0},
        '{ROW_ITEM,    '0, '0, '{15'd10, 15'd10, 15'd11, 15'd11}, '0},
        '{ROW_ITEM,    '0, '0, '{15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF}, '0},
        '{ROW_ITEM,    '0, '0, '{15'd0, 15'd0, 15'd0, 15'd0}, '0},
        '{ROW_ITEM,    '0, '0, '{15'h2AAA, 15'h5555, 15'h2AAA, 15'h5555}, '0},
        // upper bits set, bit 0 clear: back to pair mode
        '{ROW_CFG, 8'(REG_MODE_INDEX), 32'hFFFF_FFFE, '0, '0},
        '{ROW_ITEM,    '0, '0, '{15'd6, 15'd2, 15'h7FFF, 15'd0}, '0}
    };

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    gcc_item_if   item_ch ();
    gcc_result_if result_ch ();

    greedy_conflict_coloring dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (item_ch),
        .result  (result_ch)
    );

    always #CLK_HALF clk = ~clk;

    // ---------------------------------------------------------------
    // Predictor state: one used-color mask per vertex, a request count
    // per color, the number of colors in use and the mode register.
    // All zero at reset, like the block after its clearing pass.
    // ---------------------------------------------------------------
    bit [COLOR_SLOTS-1:0] vertex_colors [VERTEX_COUNT];
    bit [RANK_W-1:0]      color_items [COLOR_SLOTS];
    bit [USED_W-1:0]      colors_in_use;
    bit                   tetra_mode;

    coloring_t pending_colorings [$];
    int        colorings_predicted;
    int        mismatches;

    // what the sender is offering: how to check it, and the typed result
    row_kind_e drive_kind;
    coloring_t drive_expect;
    int        burst_left;
    bit        long_stall_req;

    // First-fit coloring of one request. Returns 1 when the request gives
    // a result; updates the masks and counts only on a real assignment.
    function automatic bit predict_coloring(input vertex_set_t req, output coloring_t res);
        vertex_t              vtx [4];
        logic [COLOR_SLOTS-1:0] busy;
        int                   corners;
        int                   pick;
        vtx[0]  = req.vertex_0;
        vtx[1]  = req.vertex_1;
        vtx[2]  = req.vertex_2;
        vtx[3]  = req.vertex_3;
        res     = '0;
        corners = tetra_mode ? 4 : 2;
        if (!tetra_mode && vtx[0] == vtx[1])
            return 1'b0;
        for (int i = 0; i < corners; i++)
        begin
            if (int'(vtx[i]) >= VERTEX_COUNT)
                return 1'b0;
        end
        // colors past MAX_COLORS count as taken
        busy = ~ALLOWED_MASK;
        for (int i = 0; i < corners; i++)
            busy |= vertex_colors[vtx[i]];
        if (&busy)
        begin
            // nothing free: report, leave state alone
            res.colors_used = colors_in_use;
            res.overflow    = 1'b1;
            return 1'b1;
        end
        pick = 0;
        while (busy[pick])
            pick++;
        for (int i = 0; i < corners; i++)
            vertex_colors[vtx[i]][pick] = 1'b1;
        res.color         = COLOR_W'(pick);
        res.rank_in_color = color_items[pick];
        // count saturates at the limit; later requests report the limit
        if (int'(color_items[pick]) < COUNT_LIMIT)
            color_items[pick]++;
        if (pick + 1 > int'(colors_in_use))
            colors_in_use = USED_W'(pick + 1);
        res.colors_used = colors_in_use;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string field, input longint want, input longint got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    endtask

    // ---------------------------------------------------------------
    // Scoreboard. Results are checked before the request of the same
    // edge is predicted; a result can never belong to a request that is
    // accepted at that same edge.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        coloring_t   want;
        coloring_t   got;
        coloring_t   predicted;
        vertex_set_t req;
        bit          makes_result;
        if (result_ch.valid && result_ch.ready)
        begin
            got = '{result_ch.color, result_ch.rank_in_color,
                    result_ch.colors_used, result_ch.overflow};
            if (pending_colorings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result color=%0d rank=%0d used=%0d overflow=%0b",
                             $time, got.color, got.rank_in_color, got.colors_used,
                             got.overflow);
            end
            else
            begin
                want = pending_colorings.pop_front();
                if (got.color !== want.color)
                    report_mismatch("color", want.color, got.color);
                if (got.rank_in_color !== want.rank_in_color)
                    report_mismatch("rank_in_color", want.rank_in_color, got.rank_in_color);
                if (got.colors_used !== want.colors_used)
                    report_mismatch("colors_used", want.colors_used, got.colors_used);
                if (got.overflow !== want.overflow)
                    report_mismatch("overflow", want.overflow, got.overflow);
            end
        end
        if (item_ch.valid && item_ch.ready)
        begin
            req = '{item_ch.vertex_0, item_ch.vertex_1, item_ch.vertex_2, item_ch.vertex_3};
            makes_result = predict_coloring(req, predicted);
            if (drive_kind == ROW_TYPED)
                pending_colorings.push_back(drive_expect);
            else if (drive_kind == ROW_ITEM && makes_result)
                pending_colorings.push_back(predicted);
            if (makes_result)
                colorings_predicted++;
        end
    end

    // ---------------------------------------------------------------
    // Sender. Requests go out in bursts; between bursts valid drops for
    // a random number of cycles. Inside a burst valid stays high.
    // ---------------------------------------------------------------
    task automatic send_request(input vertex_set_t req, input row_kind_e kind,
                                input coloring_t typed);
        if (burst_left == 0)
        begin
            @(negedge clk);
            item_ch.valid = 1'b0;
            repeat ($urandom_range(0, 10)) @(negedge clk);
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        @(negedge clk);
        item_ch.valid    = 1'b1;
        item_ch.vertex_0 = req.vertex_0;
        item_ch.vertex_1 = req.vertex_1;
        item_ch.vertex_2 = req.vertex_2;
        item_ch.vertex_3 = req.vertex_3;
        drive_kind       = kind;
        drive_expect     = typed;
        do @(posedge clk); while (!item_ch.ready);
    endtask

    // Stop offering and wait for every outstanding result, then let the
    // block finish any request that gives no result.
    task automatic drain_results(input int extra);
        @(negedge clk);
        item_ch.valid = 1'b0;
        burst_left    = 0;
        while (pending_colorings.size() != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // APB write (setup + access), then read the mode register back.
    task automatic write_reg(input int index, input logic [DATA_W-1:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'(4 * index);
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (index == REG_MODE_INDEX)
            tetra_mode = value[0];
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = PADDR_W'(4 * REG_MODE_INDEX);
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== DATA_W'(tetra_mode))
            report_mismatch("four_vertex_mode readback", tetra_mode, prdata);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Random phase. Mostly well-formed runs with random content:
    //  - hub runs: one vertex shared by a long run of requests, so its
    //    mask fills, colors climb to the top and overflow shows up
    //  - pool runs: vertices drawn from a small window, dense conflicts
    //  - noise: full-range indices, equal-vertex requests
    // Halfway through, the sender stops until every result is back.
    // ---------------------------------------------------------------
    task automatic run_random_phase(input int quota);
        vertex_set_t req;
        vertex_t     corner [4];
        vertex_t     hub;
        vertex_t     base;
        int          span;
        int          len;
        int          slot;
        int          mix;
        int          phase_start;
        bit          paused;
        phase_start = colorings_predicted;
        paused      = 1'b0;
        while (colorings_predicted - phase_start < quota)
        begin
            if (!paused && colorings_predicted - phase_start > quota / 2)
            begin
                drain_results(0);
                paused = 1'b1;
            end
            mix  = $urandom_range(0, 9);
            hub  = VERTEX_W'($urandom);
            base = VERTEX_W'($urandom);
            span = $urandom_range(2, 24);
            slot = tetra_mode ? $urandom_range(0, 3) : $urandom_range(0, 1);
            len  = (mix <= 3) ? $urandom_range(16, 96) : $urandom_range(8, 60);
            repeat (len)
            begin
                for (int i = 0; i < 4; i++)
                    corner[i] = VERTEX_W'($urandom);
                if (mix <= 3)
                begin
                    for (int i = 0; i < 4; i++)
                        corner[i] = VERTEX_W'(base + $urandom_range(0, 63));
                    corner[slot] = hub;
                end
                else if (mix <= 6)
                begin
                    for (int i = 0; i < 4; i++)
                        corner[i] = VERTEX_W'(base + $urandom_range(0, span - 1));
                end
                else if (mix == 7)
                    corner[1] = corner[0];
                req = '{corner[0], corner[1], corner[2], corner[3]};
                send_request(req, ROW_ITEM, '0);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Receiver. Switches between stall styles every so often; on request
    // it holds ready low for a long stretch so the block backs up.
    // ---------------------------------------------------------------
    initial
    begin : result_pacing
        stall_style_e style;
        int           span;
        int           period;
        int           tick;
        result_ch.ready = 1'b0;
        tick            = 0;
        forever
        begin
            if (long_stall_req)
            begin
                @(negedge clk);
                result_ch.ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                long_stall_req = 1'b0;
            end
            else
            begin
                style  = stall_style_e'($urandom_range(0, 3));
                span   = $urandom_range(16, 160);
                period = $urandom_range(2, 5);
                repeat (span)
                begin
                    @(negedge clk);
                    tick++;
                    case (style)
                        STALL_NONE:     result_ch.ready = 1'b1;
                        STALL_COIN:     result_ch.ready = 1'($urandom_range(0, 1));
                        STALL_PERIODIC: result_ch.ready = (tick % period) != 0;
                        default:        result_ch.ready = ($urandom_range(0, 3) == 0);
                    endcase
                end
            end
        end
    end

    // Watchdog: too many cycles without any handshake ends the run.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
                || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // Main sequence: reset, directed table, random phases alternating
    // between four-vertex and pair mode, final drain.
    // ---------------------------------------------------------------
    initial
    begin : stimulus
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        item_ch.valid    = 1'b0;
        item_ch.vertex_0 = '0;
        item_ch.vertex_1 = '0;
        item_ch.vertex_2 = '0;
        item_ch.vertex_3 = '0;
        drive_kind       = ROW_ITEM;
        drive_expect     = '0;
        burst_left       = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // block holds item.ready low through its clearing pass; the first
        // request simply waits for it
        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            if (DIRECTED_ROWS[i].kind == ROW_CFG)
            begin
                drain_results(SETTLE_CYCLES);
                write_reg(int'(DIRECTED_ROWS[i].reg_index), DIRECTED_ROWS[i].reg_value);
            end
            else
                send_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].kind,
                             DIRECTED_ROWS[i].result);
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain_results(SETTLE_CYCLES);
            write_reg(REG_MODE_INDEX, (p % 2 == 0) ? DATA_W'(1) : DATA_W'(0));
            // long receiver hold-off while the sender keeps offering
            if (p == 0)
                long_stall_req = 1'b1;
            run_random_phase(PHASE_QUOTA);
        end

        drain_results(SETTLE_CYCLES);
        if (mismatches == 0 && pending_colorings.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
